[design/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// constants and stage types for the hsv to rgb pixel pipeline
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_W = 15;
	localparam int CH_W  = 8;
	localparam int SV_W  = 16;
	localparam int D_W   = 12;
	localparam int P_W   = 28;
	localparam int EST_W = 9;
	localparam int DEN_W = 20;

	localparam logic [HUE_W-1:0] SECTOR_UNITS = 15'd3840;
	localparam logic [HUE_W-1:0] HUE_FULL     = 15'd23040;
	localparam logic [D_W-1:0]   D_FULL       = 12'd3840;

	// 255 * 3840, the common denominator of every component
	localparam logic [DEN_W-1:0] DEN       = 20'd979200;
	localparam logic [P_W-1:0]   DEN_ROUND = 28'd979199;

	// floor(2^28 / 979200)
	localparam logic [EST_W-1:0] RECIP       = 9'd274;
	localparam int               RECIP_SHIFT = 28;

	typedef logic [2:0] sector_t;

	localparam sector_t SECTOR_LAST = 3'd5;

	typedef struct packed {
		logic [SV_W-1:0] sv;
		logic [D_W-1:0]  d;
		sector_t         sector;
		logic [CH_W-1:0] v;
		logic            err;
	} s1_t;

	typedef struct packed {
		logic [P_W-1:0]  px;
		logic [P_W-1:0]  pz;
		sector_t         sector;
		logic [CH_W-1:0] v;
		logic            err;
	} s2_t;

	typedef struct packed {
		logic [P_W-1:0]   px;
		logic [P_W-1:0]   pz;
		logic [EST_W-1:0] ex;
		logic [EST_W-1:0] ez;
		sector_t          sector;
		logic [CH_W-1:0]  v;
		logic             err;
	} s3_t;

	typedef struct packed {
		logic [CH_W-1:0] x;
		logic [CH_W-1:0] z;
		sector_t         sector;
		logic [CH_W-1:0] v;
		logic            err;
	} s4_t;

	function automatic logic [HUE_W-1:0] sector_base(input sector_t s);
		logic [HUE_W-1:0] b;
		case (s)
			3'd0:    b = 15'd0;
			3'd1:    b = 15'd3840;
			3'd2:    b = 15'd7680;
			3'd3:    b = 15'd11520;
			3'd4:    b = 15'd15360;
			default: b = 15'd19200;
		endcase
		return b;
	endfunction

endpackage

[design/hsv_to_rgb_converter.sv]
// Pixel stream converter from hue/saturation/value to 8-bit rgb. One pixel
// is taken per clock unless the stalled pipeline holds off the input. The
// five register stages are: sector and s*v, the weighted product, the
// reciprocal estimate of the division by 255*3840, the one-step correction,
// and the output register. Each stage holds while the next one is full and
// stalled, so ready toggles through the whole pipeline in the same cycle as
// the output side. Hue above 360 degrees raises tuser and gives black.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// five stage hsv to rgb conversion with exact truncated fixed point results
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // hue[14:0], saturation[22:15], brightness[30:23]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic [0:0]  m_axis_tuser   // range_error[0]
);
	import hsv2rgb_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	s1_t st_s1, st1_d;
	s2_t st_s2, st2_d;
	s3_t st_s3, st3_d;
	s4_t st_s4, st4_d;

	logic [CH_W-1:0] red_s5, green_s5, blue_s5;
	logic            err_s5;

	// stage 1 signals
	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  sat;
	logic [CH_W-1:0]  bri;
	sector_t          sector;
	logic [HUE_W-1:0] offs;

	// stage 4 signals
	logic [P_W:0]     rem_x, rem_z;
	logic [EST_W-1:0] q_x, q_z;

	logic [P_W+EST_W-1:0] prod_x, prod_z;

	// flow control
	assign en_s5 = !vld_s5 || m_axis_tready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_axis_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: sector, distance weight and s*v
	assign hue = s_axis_tdata[14:0];
	assign sat = s_axis_tdata[22:15];
	assign bri = s_axis_tdata[30:23];

	always_comb begin
		sector = 3'd0;
		if (hue >= SECTOR_UNITS)        sector = 3'd1;
		if (hue >= 15'(2 * 3840))       sector = 3'd2;
		if (hue >= 15'(3 * 3840))       sector = 3'd3;
		if (hue >= 15'(4 * 3840))       sector = 3'd4;
		if (hue >= 15'(5 * 3840))       sector = SECTOR_LAST;
		offs = hue - sector_base(sector);

		st1_d.sv     = SV_W'(sat) * SV_W'(bri);
		st1_d.d      = sector[0] ? offs[D_W-1:0] : (D_FULL - offs[D_W-1:0]);
		st1_d.sector = sector;
		st1_d.v      = bri;
		st1_d.err    = hue > HUE_FULL;
	end

	// stage 2: weighted products with ceiling bias
	always_comb begin
		st2_d.px     = P_W'(st_s1.sv) * P_W'(st_s1.d) + DEN_ROUND;
		st2_d.pz     = P_W'(st_s1.sv) * P_W'(D_FULL) + DEN_ROUND;
		st2_d.sector = st_s1.sector;
		st2_d.v      = st_s1.v;
		st2_d.err    = st_s1.err;
	end

	// stage 3: quotient estimate by reciprocal
	always_comb begin
		prod_x = (P_W+EST_W)'(st_s2.px) * (P_W+EST_W)'(RECIP);
		prod_z = (P_W+EST_W)'(st_s2.pz) * (P_W+EST_W)'(RECIP);

		st3_d.px     = st_s2.px;
		st3_d.pz     = st_s2.pz;
		st3_d.ex     = prod_x[RECIP_SHIFT +: EST_W];
		st3_d.ez     = prod_z[RECIP_SHIFT +: EST_W];
		st3_d.sector = st_s2.sector;
		st3_d.v      = st_s2.v;
		st3_d.err    = st_s2.err;
	end

	// stage 4: correct estimate and subtract from value
	always_comb begin
		rem_x = {1'b0, st_s3.px} - ((P_W+1)'(st_s3.ex) * (P_W+1)'(DEN));
		rem_z = {1'b0, st_s3.pz} - ((P_W+1)'(st_s3.ez) * (P_W+1)'(DEN));
		q_x   = st_s3.ex + EST_W'(rem_x >= (P_W+1)'(DEN));
		q_z   = st_s3.ez + EST_W'(rem_z >= (P_W+1)'(DEN));

		st4_d.x      = st_s3.v - q_x[CH_W-1:0];
		st4_d.z      = st_s3.v - q_z[CH_W-1:0];
		st4_d.sector = st_s3.sector;
		st4_d.v      = st_s3.v;
		st4_d.err    = st_s3.err;
	end

	always_ff @(posedge clk) begin
		if (en_s1) st_s1 <= st1_d;
		if (en_s2) st_s2 <= st2_d;
		if (en_s3) st_s3 <= st3_d;
		if (en_s4) st_s4 <= st4_d;
	end

	// stage 5: sector routing and output register
	always_ff @(posedge clk) begin
		if (en_s5) begin
			err_s5 <= st_s4.err;
			if (st_s4.err) begin
				red_s5   <= '0;
				green_s5 <= '0;
				blue_s5  <= '0;
			end else begin
				case (st_s4.sector)
					3'd0: begin
						red_s5 <= st_s4.v; green_s5 <= st_s4.x; blue_s5 <= st_s4.z;
					end
					3'd1: begin
						red_s5 <= st_s4.x; green_s5 <= st_s4.v; blue_s5 <= st_s4.z;
					end
					3'd2: begin
						red_s5 <= st_s4.z; green_s5 <= st_s4.v; blue_s5 <= st_s4.x;
					end
					3'd3: begin
						red_s5 <= st_s4.z; green_s5 <= st_s4.x; blue_s5 <= st_s4.v;
					end
					3'd4: begin
						red_s5 <= st_s4.x; green_s5 <= st_s4.z; blue_s5 <= st_s4.v;
					end
					default: begin
						red_s5 <= st_s4.v; green_s5 <= st_s4.z; blue_s5 <= st_s4.x;
					end
				endcase
			end
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = {blue_s5, green_s5, red_s5};
	assign m_axis_tuser  = err_s5;

	// reciprocal estimate is never more than one short
	a_est_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (rem_x < (P_W+1)'(2 * 979200)) && (rem_z < (P_W+1)'(2 * 979200)))
		else $error("quotient estimate off by more than one");

	// subtracted part never exceeds the value
	a_q_le_v: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !st_s3.err |-> (q_x <= EST_W'(st_s3.v)) && (q_z <= EST_W'(st_s3.v)))
		else $error("component underflow");

	// out of range hue gives black
	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("range error without black output");

	// a stalled stage keeps its request
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !en_s4 |=> vld_s4 && $stable(st_s4))
		else $error("stalled request lost in stage 4");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level check of the hsv to rgb pixel converter: a directed table
// covering sector edges, the 360 degree hue, out-of-range hues and saturation
// and value extremes, then random pixels checked against a bit-exact
// fixed point color model, under four idle and stall mixes
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned SEXTANT   = 3840;
	localparam int unsigned HUE_360   = 23040;
	localparam longint unsigned SCALE = 979200;
	localparam int PHASE_PIXELS       = 488;
	localparam int DRAIN_CYCLES       = 16;

	typedef enum int {
		SEC_RED_YEL, SEC_YEL_GRN, SEC_GRN_CYN, SEC_CYN_BLU, SEC_BLU_MAG, SEC_MAG_RED
	} sextant_e;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       range_error;
	} rgb_px_t;

	typedef struct {
		logic [14:0] hue;
		logic [7:0]  sat;
		logic [7:0]  val;
		bit          typed;
		rgb_px_t     want;
	} pixel_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int          bad_results = 0;
	rgb_px_t     pending_rgb[$];
	pixel_row_t  pixel_table[$];

	hsv_to_rgb_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] weighted_channel(input int unsigned v, input int unsigned s,
			input int unsigned w);
		longint unsigned num;
		num = longint'(v) * SCALE - longint'(s) * longint'(v) * longint'(SEXTANT - w);
		return 8'(num / SCALE);
	endfunction

	function automatic rgb_px_t hsv_pixel_to_rgb(input logic [14:0] hue, input logic [7:0] sat,
			input logic [7:0] val);
		rgb_px_t     px;
		int unsigned hm;
		int unsigned mid_gap;
		int unsigned f;
		int unsigned sec;
		logic [7:0]  cc;
		logic [7:0]  xc;
		logic [7:0]  zc;
		px = '0;
		if (hue > HUE_360) begin
			px.range_error = 1'b1;
			return px;
		end
		hm      = hue % (2 * SEXTANT);
		mid_gap = (hm >= SEXTANT) ? hm - SEXTANT : SEXTANT - hm;
		f       = SEXTANT - mid_gap;
		cc   = weighted_channel(val, sat, SEXTANT);
		xc   = weighted_channel(val, sat, f);
		zc   = weighted_channel(val, sat, 0);
		sec  = hue / SEXTANT;
		if (sec > SEC_MAG_RED)
			sec = SEC_MAG_RED;
		case (sextant_e'(sec))
			SEC_RED_YEL: px = '{cc, xc, zc, 1'b0};
			SEC_YEL_GRN: px = '{xc, cc, zc, 1'b0};
			SEC_GRN_CYN: px = '{zc, cc, xc, 1'b0};
			SEC_CYN_BLU: px = '{zc, xc, cc, 1'b0};
			SEC_BLU_MAG: px = '{xc, zc, cc, 1'b0};
			default:     px = '{cc, zc, xc, 1'b0};
		endcase
		return px;
	endfunction

	// hold the request until accepted, then log what should come out
	task automatic send_pixel(input logic [14:0] hue, input logic [7:0] sat,
			input logic [7:0] val, input bit typed, input rgb_px_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, val, sat, hue};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_rgb.push_back(typed ? want : hsv_pixel_to_rgb(hue, sat, val));
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_rgb.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		rgb_px_t got;
		rgb_px_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tuser[0]};
			if (pending_rgb.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result r=%0d g=%0d b=%0d err=%0d",
						got.red, got.green, got.blue, got.range_error);
			end else begin
				want = pending_rgb.pop_front();
				if (got !== want) begin
					bad_results++;
					if (bad_results <= 10)
						$display("mismatch exp r=%0d g=%0d b=%0d err=%0d got r=%0d g=%0d b=%0d err=%0d",
							want.red, want.green, want.blue, want.range_error,
							got.red, got.green, got.blue, got.range_error);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("hsv_to_rgb_converter verification failed");
		$finish;
	end

	initial begin
		int unsigned pick;
		int          h;
		logic [14:0] hue;
		logic [7:0]  sat;
		logic [7:0]  val;

		pixel_table.push_back('{15'd0,     8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}});
		pixel_table.push_back('{15'd3840,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}});
		pixel_table.push_back('{15'd7680,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}});
		pixel_table.push_back('{15'd11520, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}});
		pixel_table.push_back('{15'd15360, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}});
		pixel_table.push_back('{15'd19200, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}});
		// full turn lands in the last sector
		pixel_table.push_back('{15'd23040, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}});
		// hue past a full turn forces black
		pixel_table.push_back('{15'd23041, 8'd255, 8'd255, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}});
		pixel_table.push_back('{15'd32767, 8'd0,   8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}});
		pixel_table.push_back('{15'd32767, 8'd255, 8'd255, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}});
		pixel_table.push_back('{15'd24000, 8'd17,  8'd99,  1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}});
		pixel_table.push_back('{15'd12345, 8'd0,   8'd200, 1'b1, '{8'd200, 8'd200, 8'd200, 1'b0}});
		pixel_table.push_back('{15'd5000,  8'd255, 8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}});
		pixel_table.push_back('{15'd0,     8'd0,   8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}});
		pixel_table.push_back('{15'd0,     8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}});
		pixel_table.push_back('{15'd3839,  8'd255, 8'd255, 1'b0, '0});
		pixel_table.push_back('{15'd1920,  8'd255, 8'd255, 1'b0, '0});
		pixel_table.push_back('{15'd7679,  8'd255, 8'd255, 1'b0, '0});
		pixel_table.push_back('{15'd19199, 8'd255, 8'd255, 1'b0, '0});
		pixel_table.push_back('{15'd23039, 8'd200, 8'd100, 1'b0, '0});
		pixel_table.push_back('{15'd22000, 8'd128, 8'd255, 1'b0, '0});
		pixel_table.push_back('{15'd9000,  8'd1,   8'd1,   1'b0, '0});
		pixel_table.push_back('{15'd16383, 8'd170, 8'd85,  1'b0, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (pixel_table[i])
			send_pixel(pixel_table[i].hue, pixel_table[i].sat, pixel_table[i].val,
				pixel_table[i].typed, pixel_table[i].want);
		wait_results_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1:       begin tx_idle_pct = 48; rx_stall_pct = 0;  end
				2:       begin tx_idle_pct = 0;  rx_stall_pct = 48; end
				default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
			endcase
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					h = $urandom_range(32767, HUE_360 + 1);
				end else if (pick < 22) begin
					// around a sector edge
					h = $urandom_range(6) * SEXTANT + $urandom_range(2) - 1;
					if (h < 0)
						h = 0;
				end else begin
					h = $urandom_range(HUE_360);
				end
				hue = 15'(h);
				pick = $urandom_range(99);
				sat = (pick < 8) ? 8'd0 : (pick < 16) ? 8'd255 : 8'($urandom_range(255));
				pick = $urandom_range(99);
				val = (pick < 8) ? 8'd0 : (pick < 16) ? 8'd255 : 8'($urandom_range(255));
				send_pixel(hue, sat, val, 1'b0, '0);
			end
			wait_results_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rgb.size() != 0)
			bad_results++;
		if (bad_results == 0)
			$display("hsv_to_rgb_converter verification clean");
		else
			$display("hsv_to_rgb_converter verification failed");
		$finish;
	end

endmodule

[sim.f]
design/hsv2rgb_pkg.sv
design/hsv_to_rgb_converter.sv
verif/tb_top.sv
